### sv/vdd_pkg.sv
// Shared widths, result codes and pipeline side-band type for the Voronoi dual block.
`timescale 1ns / 1ps
`default_nettype none
package vdd_pkg;

  localparam int CW    = 16;
  localparam int DW    = 17;
  localparam int PW    = 34;
  localparam int DDW   = 36;
  localparam int LW    = 33;
  localparam int BPW   = 51;
  localparam int NW    = 52;
  localparam int NMW   = 51;
  localparam int DMW   = 35;
  localparam int QW    = 50;
  localparam int FRAC1 = 17;
  localparam int SATSH = 33;
  localparam int LOW   = QW - FRAC1;
  localparam int RW    = 36;
  localparam int OW    = 48;
  localparam int SW    = 10;
  localparam int TW    = 11;

  localparam logic signed [OW-1:0] Q_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] Q_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CORNER = 2'd1,
    ERR_DEGEN  = 2'd2
  } err_t;

  typedef struct packed {
    err_t                     err;
    logic [TW-1:0]            tid;
    logic [2:0][TW-1:0]       nb;
    logic [2:0]               mask;
    logic [2:0][SW-1:0]       lo;
    logic [2:0][SW-1:0]       hi;
    logic signed [CW-1:0]     ox;
    logic signed [CW-1:0]     oy;
  } side_t;

  typedef struct packed {
    side_t sd;
    logic  satx;
    logic  saty;
    logic  negx;
    logic  negy;
  } dside_t;

endpackage
`default_nettype wire

### sv/voronoi_dual_from_delaunay.sv
// Voronoi vertices and edges from Delaunay triangles by circumcentres.
// Triangles go through the pipeline one item a cycle while in_stall is low; the single result
// port emits one beat a cycle while out_stall is low, and a triangle gives 1 to 4 beats there
// (a vertex beat plus one per marked edge, or a single error beat). Site loads give no result.
// Reset clears all valid bits, the pending result beats and the site limit; the site store is
// not cleared.
`timescale 1ns / 1ps
`default_nettype none
module voronoi_dual_from_delaunay #(
  parameter int MAX_SITES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [10:0]                    cfg_num_sites,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_mode,
  input  wire logic signed [10:0]             in_site_a,
  input  wire logic signed [10:0]             in_site_b,
  input  wire logic signed [10:0]             in_site_c,
  input  wire logic signed [15:0]             in_coord_x,
  input  wire logic signed [15:0]             in_coord_y,
  input  wire logic [10:0]                    in_triangle_id,
  input  wire logic signed [11:0]             in_neighbor_0,
  input  wire logic signed [11:0]             in_neighbor_1,
  input  wire logic signed [11:0]             in_neighbor_2,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_kind,
  output logic [1:0]                          out_error_code,
  output logic signed [47:0]                  out_center_x,
  output logic signed [47:0]                  out_center_y,
  output logic [10:0]                         out_edge_from_vertex,
  output logic [10:0]                         out_edge_to_vertex,
  output logic [9:0]                          out_low_site,
  output logic [9:0]                          out_high_site,
  output logic                                out_last
);

  localparam int DEPTH = (MAX_SITES < 1024) ? MAX_SITES : 1024;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [31:0] MAXS = 32'(MAX_SITES);
  localparam int QW    = vdd_pkg::QW;

  logic adv;
  logic ser_take;

  // configuration
  logic [10:0] nsites_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsites_r <= '0;
    end else if (cfg_valid) begin
      nsites_r <= cfg_num_sites;
    end
  end

  // site store, one copy per corner
  logic [31:0] mem0 [DEPTH];
  logic [31:0] mem1 [DEPTH];
  logic [31:0] mem2 [DEPTH];
  logic        wr_en;

  assign wr_en = in_valid && !in_stall && !in_mode && !in_site_a[10]
                 && ({21'b0, in_site_a} < MAXS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem0[in_site_a[AW-1:0]] <= {in_coord_y, in_coord_x};
      mem1[in_site_a[AW-1:0]] <= {in_coord_y, in_coord_x};
      mem2[in_site_a[AW-1:0]] <= {in_coord_y, in_coord_x};
    end
  end

  // stage 0: input beat
  logic               v0_r;
  logic signed [10:0] s0a_r, s0b_r, s0c_r;
  logic [10:0]        s0t_r;
  logic signed [11:0] s0n0_r, s0n1_r, s0n2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0a_r  <= in_site_a;
      s0b_r  <= in_site_b;
      s0c_r  <= in_site_c;
      s0t_r  <= in_triangle_id;
      s0n0_r <= in_neighbor_0;
      s0n1_r <= in_neighbor_1;
      s0n2_r <= in_neighbor_2;
    end
  end

  // stage 1: corner checks, store read
  logic [31:0]           lim;
  logic                  bad;
  vdd_pkg::side_t        sd1_nxt, sd1_r;
  logic [31:0]           rd0_r, rd1_r, rd2_r;
  logic                  v1_r;
  logic [2:0][10:0]      nbf;
  logic [2:0][9:0]       ep, eq;

  always_comb begin
    lim = ({21'b0, nsites_r} < MAXS) ? {21'b0, nsites_r} : MAXS;
    bad = s0a_r[10] || s0b_r[10] || s0c_r[10]
          || ({21'b0, s0a_r} >= lim) || ({21'b0, s0b_r} >= lim) || ({21'b0, s0c_r} >= lim)
          || (s0a_r == s0b_r) || (s0b_r == s0c_r) || (s0a_r == s0c_r);
    nbf = {s0n2_r[10:0], s0n1_r[10:0], s0n0_r[10:0]};
    ep  = {s0c_r[9:0], s0b_r[9:0], s0a_r[9:0]};
    eq  = {s0a_r[9:0], s0c_r[9:0], s0b_r[9:0]};
    sd1_nxt.err     = bad ? vdd_pkg::ERR_CORNER : vdd_pkg::ERR_NONE;
    sd1_nxt.tid     = s0t_r;
    sd1_nxt.nb      = nbf;
    sd1_nxt.mask[0] = !s0n0_r[11] && (s0n0_r[10:0] > s0t_r);
    sd1_nxt.mask[1] = !s0n1_r[11] && (s0n1_r[10:0] > s0t_r);
    sd1_nxt.mask[2] = !s0n2_r[11] && (s0n2_r[10:0] > s0t_r);
    for (int k = 0; k < 3; k++) begin
      sd1_nxt.lo[k] = (ep[k] < eq[k]) ? ep[k] : eq[k];
      sd1_nxt.hi[k] = (ep[k] < eq[k]) ? eq[k] : ep[k];
    end
    sd1_nxt.ox = '0;
    sd1_nxt.oy = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1_r <= sd1_nxt;
      rd0_r <= mem0[s0a_r[AW-1:0]];
      rd1_r <= mem1[s0b_r[AW-1:0]];
      rd2_r <= mem2[s0c_r[AW-1:0]];
    end
  end

  // stage 2: edge vectors
  logic                           v2_r;
  vdd_pkg::side_t                 sd2_nxt, sd2_r;
  logic signed [vdd_pkg::DW-1:0]  ax_r, ay_r, cx_r, cy_r;

  always_comb begin
    sd2_nxt    = sd1_r;
    sd2_nxt.ox = $signed(rd0_r[15:0]);
    sd2_nxt.oy = $signed(rd0_r[31:16]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd2_r <= sd2_nxt;
      ax_r <= 17'($signed(rd1_r[15:0]))  - 17'($signed(rd0_r[15:0]));
      ay_r <= 17'($signed(rd1_r[31:16])) - 17'($signed(rd0_r[31:16]));
      cx_r <= 17'($signed(rd2_r[15:0]))  - 17'($signed(rd0_r[15:0]));
      cy_r <= 17'($signed(rd2_r[31:16])) - 17'($signed(rd0_r[31:16]));
    end
  end

  // stage 3: small products
  logic                           v3_r;
  vdd_pkg::side_t                 sd3_r;
  logic signed [vdd_pkg::DW-1:0]  ax3_r, ay3_r, cx3_r, cy3_r;
  logic signed [vdd_pkg::PW-1:0]  pxy_r, pyx_r, paa_r, pbb_r, pcc_r, pdd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd3_r <= sd2_r;
      ax3_r <= ax_r;
      ay3_r <= ay_r;
      cx3_r <= cx_r;
      cy3_r <= cy_r;
      pxy_r <= ax_r * cy_r;
      pyx_r <= ay_r * cx_r;
      paa_r <= ax_r * ax_r;
      pbb_r <= ay_r * ay_r;
      pcc_r <= cx_r * cx_r;
      pdd_r <= cy_r * cy_r;
    end
  end

  // stage 4: determinant and squared lengths
  logic                            v4_r;
  vdd_pkg::side_t                  sd4_r;
  logic signed [vdd_pkg::DW-1:0]   ax4_r, ay4_r, cx4_r, cy4_r;
  logic signed [vdd_pkg::DDW-1:0]  dd4_r;
  logic [vdd_pkg::LW-1:0]          la_r, lc_r;
  logic signed [vdd_pkg::PW:0]     det_d, la_s, lc_s;

  always_comb begin
    det_d = 35'(pxy_r) - 35'(pyx_r);
    la_s  = 35'(paa_r) + 35'(pbb_r);
    lc_s  = 35'(pcc_r) + 35'(pdd_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd4_r <= sd3_r;
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;
      cx4_r <= cx3_r;
      cy4_r <= cy3_r;
      dd4_r <= {det_d, 1'b0};
      la_r  <= la_s[vdd_pkg::LW-1:0];
      lc_r  <= lc_s[vdd_pkg::LW-1:0];
    end
  end

  // stage 5: wide products
  logic                            v5_r;
  vdd_pkg::side_t                  sd5_nxt, sd5_r;
  logic signed [vdd_pkg::DDW-1:0]  dd5_r;
  logic signed [vdd_pkg::BPW-1:0]  q1_r, q2_r, q3_r, q4_r;
  logic signed [vdd_pkg::LW:0]     las, lcs;

  assign las = $signed({1'b0, la_r});
  assign lcs = $signed({1'b0, lc_r});

  always_comb begin
    sd5_nxt = sd4_r;
    if (dd4_r == '0 && sd4_r.err == vdd_pkg::ERR_NONE) begin
      sd5_nxt.err = vdd_pkg::ERR_DEGEN;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd5_r <= sd5_nxt;
      dd5_r <= dd4_r;
      q1_r  <= cy4_r * las;
      q2_r  <= ay4_r * lcs;
      q3_r  <= ax4_r * lcs;
      q4_r  <= cx4_r * las;
    end
  end

  // stage 6: numerators
  logic                            v6_r;
  vdd_pkg::side_t                  sd6_r;
  logic signed [vdd_pkg::DDW-1:0]  dd6_r;
  logic signed [vdd_pkg::NW-1:0]   nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd6_r <= sd5_r;
      dd6_r <= dd5_r;
      nx_r  <= 52'(q1_r) - 52'(q2_r);
      ny_r  <= 52'(q3_r) - 52'(q4_r);
    end
  end

  // stage 7: magnitudes and signs
  logic                       v7_r;
  vdd_pkg::side_t             sd7_r;
  logic [vdd_pkg::NMW-1:0]    nmx_r, nmy_r;
  logic [vdd_pkg::DMW-1:0]    dm_r;
  logic                       ngx_r, ngy_r;
  logic [vdd_pkg::NW-1:0]     nxa, nya;
  logic [vdd_pkg::DDW-1:0]    dda;

  always_comb begin
    nxa = nx_r[vdd_pkg::NW-1]   ? 52'(-nx_r)  : 52'(nx_r);
    nya = ny_r[vdd_pkg::NW-1]   ? 52'(-ny_r)  : 52'(ny_r);
    dda = dd6_r[vdd_pkg::DDW-1] ? 36'(-dd6_r) : 36'(dd6_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd7_r <= sd6_r;
      nmx_r <= nxa[vdd_pkg::NMW-1:0];
      nmy_r <= nya[vdd_pkg::NMW-1:0];
      dm_r  <= dda[vdd_pkg::DMW-1:0];
      ngx_r <= nx_r[vdd_pkg::NW-1] != dd6_r[vdd_pkg::DDW-1];
      ngy_r <= ny_r[vdd_pkg::NW-1] != dd6_r[vdd_pkg::DDW-1];
    end
  end

  // stage 8 and divider: saturation check, quotient bits
  vdd_pkg::dside_t  dl_nxt;
  vdd_pkg::dside_t  dl_r [QW+1];
  logic             dv_r [QW+1];
  logic [67:0]      dsh;
  logic [QW-1:0]    qx, qy;

  always_comb begin
    dsh         = {dm_r, 33'b0};
    dl_nxt.sd   = sd7_r;
    dl_nxt.satx = {17'b0, nmx_r} >= dsh;
    dl_nxt.saty = {17'b0, nmy_r} >= dsh;
    dl_nxt.negx = ngx_r;
    dl_nxt.negy = ngy_r;
  end

  vdd_div u_divx (
    .clk    (clk),
    .en     (adv),
    .num_lo (nmx_r[vdd_pkg::LOW-1:0]),
    .rem0   (36'(nmx_r[vdd_pkg::NMW-1:vdd_pkg::SATSH])),
    .den    (dm_r),
    .quo    (qx)
  );

  vdd_div u_divy (
    .clk    (clk),
    .en     (adv),
    .num_lo (nmy_r[vdd_pkg::LOW-1:0]),
    .rem0   (36'(nmy_r[vdd_pkg::NMW-1:vdd_pkg::SATSH])),
    .den    (dm_r),
    .quo    (qy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= dl_nxt;
      for (int j = 0; j < QW; j++) begin
        dl_r[j+1] <= dl_r[j];
      end
    end
  end

  // round, sign and offset
  logic                    vr1_r;
  vdd_pkg::side_t          sr1_r;
  logic signed [50:0]      mx_r, my_r;
  logic [50:0]             rx, ry;
  logic [49:0]             mgx, mgy;

  always_comb begin
    rx  = {1'b0, qx} + 51'd1;
    ry  = {1'b0, qy} + 51'd1;
    mgx = dl_r[QW].satx ? (50'd1 << 49) : rx[50:1];
    mgy = dl_r[QW].saty ? (50'd1 << 49) : ry[50:1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr1_r <= dl_r[QW].sd;
      mx_r  <= dl_r[QW].negx ? -$signed({1'b0, mgx}) : $signed({1'b0, mgx});
      my_r  <= dl_r[QW].negy ? -$signed({1'b0, mgy}) : $signed({1'b0, mgy});
    end
  end

  logic                    vr2_r;
  vdd_pkg::side_t          sr2_r;
  logic signed [47:0]      ctx_r, cty_r;
  logic signed [52:0]      sx, sy;

  always_comb begin
    sx = 53'(mx_r) + 53'($signed({sr1_r.ox, 16'b0}));
    sy = 53'(my_r) + 53'($signed({sr1_r.oy, 16'b0}));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr2_r <= sr1_r;
      priority if (sx > 53'(vdd_pkg::Q_MAX)) begin
        ctx_r <= vdd_pkg::Q_MAX;
      end else if (sx < 53'(vdd_pkg::Q_MIN)) begin
        ctx_r <= vdd_pkg::Q_MIN;
      end else begin
        ctx_r <= sx[47:0];
      end
      priority if (sy > 53'(vdd_pkg::Q_MAX)) begin
        cty_r <= vdd_pkg::Q_MAX;
      end else if (sy < 53'(vdd_pkg::Q_MIN)) begin
        cty_r <= vdd_pkg::Q_MIN;
      end else begin
        cty_r <= sy[47:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      vr1_r <= 1'b0;
      vr2_r <= 1'b0;
      for (int j = 0; j <= QW; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else if (adv) begin
      v0_r    <= in_valid && in_mode;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      dv_r[0] <= v7_r;
      for (int j = 0; j < QW; j++) begin
        dv_r[j+1] <= dv_r[j];
      end
      vr1_r <= dv_r[QW];
      vr2_r <= vr1_r;
    end
  end

  // result serialiser
  logic [3:0]          srem_r, srem_nxt;
  vdd_pkg::side_t      ssd_r;
  logic signed [47:0]  scx_r, scy_r;
  logic [3:0]          low, rest;
  logic                fire;

  always_comb begin
    low      = srem_r & (~srem_r + 4'd1);
    rest     = srem_r & ~low;
    fire     = (srem_r != '0) && !out_stall;
    ser_take = vr2_r && ((srem_r == '0) || (fire && rest == '0));
    adv      = !vr2_r || ser_take;
    in_stall = !adv;
    srem_nxt = srem_r;
    if (ser_take) begin
      srem_nxt = (sr2_r.err != vdd_pkg::ERR_NONE) ? 4'b0001 : {sr2_r.mask, 1'b1};
    end else if (fire) begin
      srem_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srem_r <= '0;
    end else begin
      srem_r <= srem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ssd_r <= sr2_r;
      scx_r <= ctx_r;
      scy_r <= cty_r;
    end
  end

  always_comb begin
    out_valid            = (srem_r != '0);
    out_last             = (rest == '0);
    out_kind             = vdd_pkg::KIND_EDGE;
    out_error_code       = vdd_pkg::ERR_NONE;
    out_center_x         = '0;
    out_center_y         = '0;
    out_edge_from_vertex = '0;
    out_edge_to_vertex   = '0;
    out_low_site         = '0;
    out_high_site        = '0;
    unique case (low)
      4'b0010: begin
        out_edge_from_vertex = ssd_r.tid;
        out_edge_to_vertex   = ssd_r.nb[0];
        out_low_site         = ssd_r.lo[0];
        out_high_site        = ssd_r.hi[0];
      end
      4'b0100: begin
        out_edge_from_vertex = ssd_r.tid;
        out_edge_to_vertex   = ssd_r.nb[1];
        out_low_site         = ssd_r.lo[1];
        out_high_site        = ssd_r.hi[1];
      end
      4'b1000: begin
        out_edge_from_vertex = ssd_r.tid;
        out_edge_to_vertex   = ssd_r.nb[2];
        out_low_site         = ssd_r.lo[2];
        out_high_site        = ssd_r.hi[2];
      end
      default: begin
        if (ssd_r.err != vdd_pkg::ERR_NONE) begin
          out_kind       = vdd_pkg::KIND_ERROR;
          out_error_code = ssd_r.err;
        end else begin
          out_kind     = vdd_pkg::KIND_VERTEX;
          out_center_x = scx_r;
          out_center_y = scy_r;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/vdd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vdd_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [vdd_pkg::LOW-1:0]      num_lo,
  input  wire logic [vdd_pkg::RW-1:0]       rem0,
  input  wire logic [vdd_pkg::DMW-1:0]      den,
  output logic      [vdd_pkg::QW-1:0]       quo
);

  logic [vdd_pkg::RW-1:0]  rem_r [vdd_pkg::QW+1];
  logic [vdd_pkg::QW-1:0]  quo_r [vdd_pkg::QW+1];
  logic [vdd_pkg::LOW-1:0] lo_r  [vdd_pkg::QW];
  logic [vdd_pkg::DMW-1:0] den_r [vdd_pkg::QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      quo_r[0] <= '0;
      lo_r[0]  <= num_lo;
      den_r[0] <= den;
    end
  end

  for (genvar j = 0; j < vdd_pkg::QW; j++) begin : g_stage
    localparam int I = vdd_pkg::QW - 1 - j;
    logic                   nbit;
    logic [vdd_pkg::RW:0]   trial;
    logic [vdd_pkg::RW:0]   dext;
    logic [vdd_pkg::RW:0]   diff;
    logic                   ge;
    logic [vdd_pkg::QW-1:0] qbit;

    if (I >= vdd_pkg::FRAC1) begin : g_bit
      assign nbit = lo_r[j][I-vdd_pkg::FRAC1];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {rem_r[j], nbit};
    assign dext  = {{(vdd_pkg::RW+1-vdd_pkg::DMW){1'b0}}, den_r[j]};
    assign ge    = (trial >= dext);
    assign diff  = trial - dext;
    assign qbit  = {{(vdd_pkg::QW-1){1'b0}}, ge} << I;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? diff[vdd_pkg::RW-1:0] : trial[vdd_pkg::RW-1:0];
        quo_r[j+1] <= quo_r[j] | qbit;
      end
    end

    if (j + 1 < vdd_pkg::QW) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          lo_r[j+1]  <= lo_r[j];
          den_r[j+1] <= den_r[j];
        end
      end
    end
  end

  assign quo = quo_r[vdd_pkg::QW];

endmodule
`default_nettype wire
